FILE: hdl/seven_segment_number_writer_defines.svh
// assertion macros for the seven-segment number writer
`ifndef SEVEN_SEGMENT_NUMBER_WRITER_DEFINES_SVH
`define SEVEN_SEGMENT_NUMBER_WRITER_DEFINES_SVH

`ifndef SYNTHESIS
// condition implies consequence in the same cycle
`define SSNW_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// condition implies consequence in the following cycle
`define SSNW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SSNW_ASSERT_NOW(label, clk, rst, ante, cons)
`define SSNW_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: hdl/ssnw_pkg.sv
// constants and segment table for the seven-segment number writer
package ssnw_pkg;

   localparam int MAX_DIGITS = 6;
   localparam int VALUE_W    = 20;
   localparam int DC_W       = 3;

   // digit count width: holds MAX_DIGITS and the 3-bit request field
   localparam int CNT_W = ($clog2(MAX_DIGITS + 1) > DC_W) ? $clog2(MAX_DIGITS + 1) : DC_W;
   localparam int DIG_IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int STEP_W = CNT_W + 1;

   // divide by ten as multiply by ceil(2^23 / 10), exact below 2^22
   localparam int RECIP_SHIFT = 23;
   localparam logic [VALUE_W-1:0] RECIP = VALUE_W'(((1 << RECIP_SHIFT) + 9) / 10);

   localparam logic [7:0] CMD_DATA_MODE = 8'h40;
   localparam logic [7:0] CMD_ADDR_BASE = 8'd192;
   localparam logic [7:0] CTRL_RESET    = 8'h8A;
   localparam logic [7:0] COLON_MASK    = 8'h80;

   function automatic logic [7:0] seg_code(input logic [3:0] digit);
      logic [7:0] code;
      unique case (digit)
         4'd0:    code = 8'b0011_1111;
         4'd1:    code = 8'b0000_0110;
         4'd2:    code = 8'b0101_1011;
         4'd3:    code = 8'b0100_1111;
         4'd4:    code = 8'b0110_0110;
         4'd5:    code = 8'b0110_1101;
         4'd6:    code = 8'b0111_1101;
         4'd7:    code = 8'b0000_0111;
         4'd8:    code = 8'b0111_1111;
         4'd9:    code = 8'b0110_0111;
         default: code = 8'b0000_0000;
      endcase
      return code;
   endfunction

endpackage

FILE: hdl/seven_segment_number_writer.sv
// seven-segment number writer: digit split and display command byte sequencer
//
// Takes one request at a time and turns it into the byte stream for a two-wire
// seven-segment display: a data-mode frame, an address frame with one segment
// code per digit, and a display-control frame carrying csr_write_data as last
// written (0x8A after reset). A request is captured, then the value goes
// through a shared divide-by-ten unit (one multiply by a reciprocal and a
// shift-add remainder) once per digit position, MAX_DIGITS (6) of them, while
// the significant digit count is tracked. Bytes then leave one per cycle from
// the output register, count + 3 of them, as long as rsp_stall is low.
// req_stall is high from capture until the display-control byte is loaded into
// the output register. last_of_run marks that display-control byte.

`include "seven_segment_number_writer_defines.svh"

module seven_segment_number_writer (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [2:0]                       req_start_position,
   input  logic                             req_right_align,
   input  logic [ssnw_pkg::VALUE_W-1:0]     req_value,
   input  logic                             req_channel,
   input  logic [ssnw_pkg::DC_W-1:0]        req_digit_count,
   input  logic                             req_colon_on,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_link_select,
   output logic [7:0]                       rsp_tx_byte,
   output logic                             rsp_frame_start,
   output logic                             rsp_frame_end,
   output logic                             rsp_last_of_run,
   // control register
   input  logic                             csr_write_enable,
   input  logic [7:0]                       csr_write_data
);

   localparam int CNT_W     = ssnw_pkg::CNT_W;
   localparam int IDX_W     = ssnw_pkg::DIG_IDX_W;
   localparam int STEP_W    = ssnw_pkg::STEP_W;
   localparam int VALUE_W   = ssnw_pkg::VALUE_W;
   localparam int PROD_W    = 2 * VALUE_W;

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   localparam logic [IDX_W-1:0] LAST_DIV = IDX_W'(ssnw_pkg::MAX_DIGITS - 1);
   localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(ssnw_pkg::MAX_DIGITS);

   logic [1:0]         state_ff, state_in;
   logic [7:0]         ctrl_ff, ctrl_in;

   // captured request
   logic [2:0]         start_ff, start_in;
   logic               right_ff, right_in;
   logic               link_ff, link_in;
   logic [CNT_W-1:0]   dcount_ff, dcount_in;
   logic               colon_ff, colon_in;

   // divide loop
   logic [VALUE_W-1:0] val_ff, val_in;
   logic [IDX_W-1:0]   div_cnt_ff, div_cnt_in;
   logic [CNT_W-1:0]   sig_ff, sig_in;
   logic [3:0]         digits_ff [ssnw_pkg::MAX_DIGITS];

   // emit sequencer
   logic [STEP_W-1:0]  step_ff, step_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_link_ff, out_link_in;
   logic [7:0]         out_byte_ff, out_byte_in;
   logic               out_fs_ff, out_fs_in;
   logic               out_fe_ff, out_fe_in;
   logic               out_last_ff, out_last_in;

   logic               req_accept;
   logic               out_load;
   logic [PROD_W-1:0]  prod;
   logic [VALUE_W-1:0] quot;
   logic [VALUE_W-1:0] quot_x10;
   logic [3:0]         rem;
   logic [CNT_W-1:0]   count;
   logic [STEP_W-1:0]  count_w;
   logic [STEP_W-1:0]  rd_wide;
   logic [7:0]         addr;
   logic [7:0]         code;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_load   = !rsp_valid_ff || !rsp_stall;

   // shared divide-by-ten unit
   assign prod     = PROD_W'(val_ff) * PROD_W'(ssnw_pkg::RECIP);
   assign quot     = VALUE_W'(prod >> ssnw_pkg::RECIP_SHIFT);
   assign quot_x10 = (quot << 3) + (quot << 1);
   assign rem      = 4'(val_ff - quot_x10);

   // digits to show: given count saturated, or the significant digits
   always_comb begin
      if (dcount_ff == '0) begin
         count = sig_ff;
      end else if (dcount_ff > MAX_CNT) begin
         count = MAX_CNT;
      end else begin
         count = dcount_ff;
      end
   end
   assign count_w = STEP_W'(count);

   // address byte, mod 256
   always_comb begin
      addr = ssnw_pkg::CMD_ADDR_BASE + 8'(start_ff);
      if (right_ff) begin
         addr = addr - 8'(count) + 8'd1;
      end
   end

   // step 2 shows the most significant kept digit, stored at count-1
   assign rd_wide = count_w + STEP_W'(1) - step_ff;
   assign code    = ssnw_pkg::seg_code(digits_ff[rd_wide[IDX_W-1:0]])
                    | (colon_ff ? ssnw_pkg::COLON_MASK : 8'h00);

   always_comb begin
      state_in     = state_ff;
      ctrl_in      = csr_write_enable ? csr_write_data : ctrl_ff;
      start_in     = start_ff;
      right_in     = right_ff;
      link_in      = link_ff;
      dcount_in    = dcount_ff;
      colon_in     = colon_ff;
      val_in       = val_ff;
      div_cnt_in   = div_cnt_ff;
      sig_in       = sig_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      out_link_in  = out_link_ff;
      out_byte_in  = out_byte_ff;
      out_fs_in    = out_fs_ff;
      out_fe_in    = out_fe_ff;
      out_last_in  = out_last_ff;

      // slot drains when taken
      if (out_load) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               start_in   = req_start_position;
               right_in   = req_right_align;
               link_in    = req_channel;
               dcount_in  = CNT_W'(req_digit_count);
               colon_in   = req_colon_on;
               val_in     = req_value;
               div_cnt_in = '0;
               sig_in     = '0;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            val_in = quot;
            // a nonzero value here means at least this many digits
            if (val_ff != '0) begin
               sig_in = CNT_W'(div_cnt_ff) + CNT_W'(1);
            end
            div_cnt_in = div_cnt_ff + IDX_W'(1);
            if (div_cnt_ff == LAST_DIV) begin
               step_in  = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               out_link_in  = link_ff;
               out_last_in  = 1'b0;
               step_in      = step_ff + STEP_W'(1);
               if (step_ff == '0) begin
                  // data-mode frame
                  out_byte_in = ssnw_pkg::CMD_DATA_MODE;
                  out_fs_in   = 1'b1;
                  out_fe_in   = 1'b1;
               end else if (step_ff == STEP_W'(1)) begin
                  // address opens the digit frame, closes it when empty
                  out_byte_in = addr;
                  out_fs_in   = 1'b1;
                  out_fe_in   = (count == '0);
               end else if (step_ff <= count_w + STEP_W'(1)) begin
                  out_byte_in = code;
                  out_fs_in   = 1'b0;
                  out_fe_in   = (step_ff == count_w + STEP_W'(1));
               end else begin
                  // display-control frame ends the request
                  out_byte_in = ctrl_ff;
                  out_fs_in   = 1'b1;
                  out_fe_in   = 1'b1;
                  out_last_in = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ctrl_ff      <= ssnw_pkg::CTRL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctrl_ff      <= ctrl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff    <= start_in;
      right_ff    <= right_in;
      link_ff     <= link_in;
      dcount_ff   <= dcount_in;
      colon_ff    <= colon_in;
      val_ff      <= val_in;
      div_cnt_ff  <= div_cnt_in;
      sig_ff      <= sig_in;
      step_ff     <= step_in;
      out_link_ff <= out_link_in;
      out_byte_ff <= out_byte_in;
      out_fs_ff   <= out_fs_in;
      out_fe_ff   <= out_fe_in;
      out_last_ff <= out_last_in;
   end

   // digit store, least significant digit at index 0
   always_ff @(posedge clock) begin
      if (state_ff == ST_DIV) begin
         digits_ff[div_cnt_ff] <= rem;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_link_select = out_link_ff;
   assign rsp_tx_byte     = out_byte_ff;
   assign rsp_frame_start = out_fs_ff;
   assign rsp_frame_end   = out_fe_ff;
   assign rsp_last_of_run = out_last_ff;

   // a captured request always starts the divide loop from digit zero
   `SSNW_ASSERT_NEXT(a_accept_starts_div, clock, reset, req_accept,
      (state_ff == ST_DIV) && (div_cnt_ff == '0))
   // the emit step never runs past the display-control byte
   `SSNW_ASSERT_NOW(a_step_bound, clock, reset, state_ff == ST_EMIT,
      step_ff <= count_w + STEP_W'(2))
   // the final byte of a request is a complete one-byte frame
   `SSNW_ASSERT_NOW(a_last_framed, clock, reset, rsp_valid_ff && out_last_ff,
      out_fs_ff && out_fe_ff && (out_byte_ff == ctrl_ff))

endmodule

FILE: tb/ssnw_checker.sv
`timescale 1ns / 100ps
// response checker: predicts display byte streams and compares them with the response channel
module ssnw_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [2:0]                   req_start_position,
   input  logic                         req_right_align,
   input  logic [ssnw_pkg::VALUE_W-1:0] req_value,
   input  logic                         req_channel,
   input  logic [ssnw_pkg::DC_W-1:0]    req_digit_count,
   input  logic                         req_colon_on,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic                         rsp_link_select,
   input  logic [7:0]                   rsp_tx_byte,
   input  logic                         rsp_frame_start,
   input  logic                         rsp_frame_end,
   input  logic                         rsp_last_of_run,
   input  logic                         csr_write_enable,
   input  logic [7:0]                   csr_write_data,
   output int                           fail_count,
   output int                           waiting_count
);

   typedef struct packed {
      logic       link;
      logic [7:0] data;
      logic       fstart;
      logic       fend;
      logic       last;
   } link_byte_type;

   localparam logic [7:0] SEGMENT_PATTERN [10] = '{
      8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h67
   };

   link_byte_type queued_bytes [$];
   logic [7:0]    control_byte;
   int            errors = 0;

   function automatic void predict_display_bytes(
      input logic [2:0]                   pos,
      input logic                         right,
      input logic [ssnw_pkg::VALUE_W-1:0] value,
      input logic                         link,
      input logic [ssnw_pkg::DC_W-1:0]    count_field,
      input logic                         colon
   );
      int                           n;
      int                           i;
      logic [ssnw_pkg::VALUE_W-1:0] v;
      logic [7:0]                   codes [ssnw_pkg::MAX_DIGITS];
      logic [7:0]                   addr;
      n = int'(count_field);
      // zero count means significant digits of the value
      if (n == 0)
         for (v = value; v > 0; v = ssnw_pkg::VALUE_W'(v / 10)) n++;
      if (n > ssnw_pkg::MAX_DIGITS) n = ssnw_pkg::MAX_DIGITS;
      v = value;
      for (i = n - 1; i >= 0; i--) begin
         codes[i] = SEGMENT_PATTERN[v % 10] | (colon ? ssnw_pkg::COLON_MASK : 8'h00);
         v = ssnw_pkg::VALUE_W'(v / 10);
      end
      addr = ssnw_pkg::CMD_ADDR_BASE + 8'(pos);
      if (right) addr = addr - 8'(n) + 8'd1;
      queued_bytes.push_back('{link, ssnw_pkg::CMD_DATA_MODE, 1'b1, 1'b1, 1'b0});
      queued_bytes.push_back('{link, addr, 1'b1, (n == 0), 1'b0});
      for (i = 0; i < n; i++)
         queued_bytes.push_back('{link, codes[i], 1'b0, (i == n - 1), 1'b0});
      queued_bytes.push_back('{link, control_byte, 1'b1, 1'b1, 1'b1});
   endfunction

   always @(posedge clock) begin
      link_byte_type seen;
      link_byte_type want;
      if (reset) begin
         control_byte = ssnw_pkg::CTRL_RESET;
         queued_bytes.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen = '{rsp_link_select, rsp_tx_byte, rsp_frame_start, rsp_frame_end,
                     rsp_last_of_run};
            if (queued_bytes.size() == 0) begin
               if (errors < 10)
                  $display("%0t unexpected byte: link %0d byte %02h start %0d end %0d last %0d",
                           $time, seen.link, seen.data, seen.fstart, seen.fend, seen.last);
               errors++;
            end else begin
               want = queued_bytes.pop_front();
               if (seen.link !== want.link || seen.data !== want.data ||
                   seen.fstart !== want.fstart || seen.fend !== want.fend ||
                   seen.last !== want.last) begin
                  if (errors < 10)
                     $display({"%0t mismatch: expected link %0d byte %02h start %0d end %0d ",
                               "last %0d, got link %0d byte %02h start %0d end %0d last %0d"},
                              $time, want.link, want.data, want.fstart, want.fend, want.last,
                              seen.link, seen.data, seen.fstart, seen.fend, seen.last);
                  errors++;
               end
            end
         end
         if (csr_write_enable)
            control_byte = csr_write_data;
         if (req_valid && !req_stall)
            predict_display_bytes(req_start_position, req_right_align, req_value,
                                  req_channel, req_digit_count, req_colon_on);
      end
      fail_count    <= errors;
      waiting_count <= queued_bytes.size();
   end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// testbench top: request stimulus, control register phases and verdict
module tb;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [2:0]                     req_start_position = '0;
   logic                           req_right_align = 1'b0;
   logic [ssnw_pkg::VALUE_W-1:0]   req_value = '0;
   logic                           req_channel = 1'b0;
   logic [ssnw_pkg::DC_W-1:0]      req_digit_count = '0;
   logic                           req_colon_on = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic                           rsp_link_select;
   logic [7:0]                     rsp_tx_byte;
   logic                           rsp_frame_start;
   logic                           rsp_frame_end;
   logic                           rsp_last_of_run;
   logic                           csr_write_enable = 1'b0;
   logic [7:0]                     csr_write_data = '0;

   int fail_count;
   int waiting_count;
   // chance in a hundred that the sender idles or the receiver stalls in a cycle
   int send_idle_pct = 0;
   int stall_pct = 0;

   // 4 ns period
   always #2 clock = ~clock;

   seven_segment_number_writer DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_start_position (req_start_position),
      .req_right_align    (req_right_align),
      .req_value          (req_value),
      .req_channel        (req_channel),
      .req_digit_count    (req_digit_count),
      .req_colon_on       (req_colon_on),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_link_select    (rsp_link_select),
      .rsp_tx_byte        (rsp_tx_byte),
      .rsp_frame_start    (rsp_frame_start),
      .rsp_frame_end      (rsp_frame_end),
      .rsp_last_of_run    (rsp_last_of_run),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   ssnw_checker byte_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_start_position (req_start_position),
      .req_right_align    (req_right_align),
      .req_value          (req_value),
      .req_channel        (req_channel),
      .req_digit_count    (req_digit_count),
      .req_colon_on       (req_colon_on),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_link_select    (rsp_link_select),
      .rsp_tx_byte        (rsp_tx_byte),
      .rsp_frame_start    (rsp_frame_start),
      .rsp_frame_end      (rsp_frame_end),
      .rsp_last_of_run    (rsp_last_of_run),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .fail_count         (fail_count),
      .waiting_count      (waiting_count)
   );

   // receiver side: random stall, redrawn every cycle
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // one request: optional idle cycles, then hold it until accepted.
   // valid is left high on return so back-to-back requests never toggle it
   task automatic put_request(
      input logic [2:0]                   pos,
      input logic                         right,
      input logic [ssnw_pkg::VALUE_W-1:0] value,
      input logic                         chan,
      input logic [ssnw_pkg::DC_W-1:0]    count,
      input logic                         colon
   );
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_start_position <= pos;
      req_right_align    <= right;
      req_value          <= value;
      req_channel        <= chan;
      req_digit_count    <= count;
      req_colon_on       <= colon;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // random request; values mostly within six digits, some small, some over range
   task automatic put_random_request();
      logic [ssnw_pkg::VALUE_W-1:0] value;
      case ($urandom_range(3))
         0:       value = ssnw_pkg::VALUE_W'($urandom_range(99));
         3:       value = ssnw_pkg::VALUE_W'($urandom_range(20'hFFFFF));
         default: value = ssnw_pkg::VALUE_W'($urandom_range(999999));
      endcase
      put_request(3'($urandom_range(7)), 1'($urandom_range(1)), value,
                  1'($urandom_range(1)), ssnw_pkg::DC_W'($urandom_range(7)),
                  1'($urandom_range(1)));
   endtask

   // sender holds off until every predicted byte has come back
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      // checker counts are registered, so let them catch up before polling
      @(posedge clock);
      while (waiting_count != 0) @(posedge clock);
   endtask

   task automatic write_control(input logic [7:0] data);
      csr_write_enable <= 1'b1;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_random_phase(input int idle_pct, input int stall_chance, input int n);
      send_idle_pct = idle_pct;
      stall_pct    <= stall_chance;
      repeat (n) put_random_request();
      wait_until_drained();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed requests at the reset control byte, no idling
      // args: position, right align, value, channel, digit count, colon
      put_request(3'd0, 1'b0, 20'd0,       1'b0, 3'd0, 1'b0); // zero value, no digits
      put_request(3'd0, 1'b1, 20'd0,       1'b0, 3'd0, 1'b0); // right aligned, no digits
      put_request(3'd0, 1'b0, 20'd0,       1'b0, 3'd1, 1'b0); // one forced zero digit
      put_request(3'd5, 1'b0, 20'd999999,  1'b1, 3'd0, 1'b1); // largest six-digit value, colon
      put_request(3'd5, 1'b1, 20'd999999,  1'b0, 3'd0, 1'b0);
      put_request(3'd0, 1'b0, 20'hFFFFF,   1'b1, 3'd0, 1'b0); // seven digits, capped
      put_request(3'd3, 1'b0, 20'd123456,  1'b0, 3'd2, 1'b0); // high digits dropped
      put_request(3'd2, 1'b1, 20'd7,       1'b1, 3'd7, 1'b1); // count saturates
      put_request(3'd6, 1'b0, 20'd42,      1'b0, 3'd0, 1'b0); // position past grid
      put_request(3'd7, 1'b1, 20'd5,       1'b1, 3'd3, 1'b1);
      put_request(3'd1, 1'b0, 20'd987654,  1'b0, 3'd6, 1'b0);
      put_request(3'd4, 1'b0, 20'd3210,    1'b1, 3'd4, 1'b0);
      put_request(3'd0, 1'b0, 20'd1,       1'b0, 3'd0, 1'b1);
      put_request(3'd2, 1'b0, 20'd10,      1'b0, 3'd0, 1'b0);
      put_request(3'd7, 1'b1, 20'd99999,   1'b1, 3'd5, 1'b0);
      put_request(3'd6, 1'b1, 20'd0,       1'b0, 3'd0, 1'b1); // right aligned empty frame
      put_request(3'd3, 1'b1, 20'd123,     1'b0, 3'd6, 1'b1); // leading zeros shown
      put_request(3'd0, 1'b1, 20'd8,       1'b1, 3'd1, 1'b0);
      wait_until_drained();

      // random phases, control byte changed while idle between them
      write_control(8'h00);
      run_random_phase(0, 0, 48);
      write_control(8'hFF);
      run_random_phase(68, 0, 48);
      write_control(8'($urandom_range(255)));
      run_random_phase(0, 68, 48);
      write_control(8'h8F);
      run_random_phase(25, 25, 48);

      // let any stray bytes show up before the verdict
      repeat (40) @(posedge clock);
      if (fail_count == 0 && waiting_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

   // watchdog far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("tb: done, errors");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/ssnw_pkg.sv
hdl/seven_segment_number_writer.sv
tb/ssnw_checker.sv
tb/tb.sv
